[hw/rtl/stcl_pkg.sv]
// Shared types, command words and constants for the serial text lamp controller.
`timescale 1ns / 1ps

package stcl_pkg;

   localparam int WORD_COUNT   = 8;
   localparam int WORD_MAX_LEN = 8;
   localparam int LEN_W        = 4;
   localparam int LAMP_W       = 3;

   localparam logic [7:0] CR_CODE = 8'd13;

   localparam logic [LAMP_W-1:0] LAMP_ALL   = 3'b111;
   localparam logic [LAMP_W-1:0] LAMP_ONE   = 3'b001;
   localparam logic [LAMP_W-1:0] LAMP_TWO   = 3'b010;
   localparam logic [LAMP_W-1:0] LAMP_THREE = 3'b100;

   typedef logic [7:0] char_type;
   // first character of a line at index 0
   typedef char_type [WORD_MAX_LEN-1:0] line_chars_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [LAMP_W-1:0] mask;
      logic              turn_on;
      line_chars_type    chars;
   } word_entry_type;

   typedef struct packed {
      logic              hit;
      logic [LAMP_W-1:0] mask;
      logic              turn_on;
   } match_type;

   // String literals are right aligned: the last character sits in the low byte.
   function automatic word_entry_type make_word(logic [63:0] text, int len,
                                                logic [LAMP_W-1:0] mask, logic turn_on);
      word_entry_type w;
      int i;
      w.len     = LEN_W'(len);
      w.mask    = mask;
      w.turn_on = turn_on;
      for (i = 0; i < WORD_MAX_LEN; i++) begin
         if (i < len) begin
            w.chars[i] = text[(len - 1 - i) * 8 +: 8];
         end else begin
            w.chars[i] = 8'h00;
         end
      end
      return w;
   endfunction

   localparam word_entry_type WORDS [WORD_COUNT] = '{
      make_word("allon",    5, LAMP_ALL,   1'b1),
      make_word("alloff",   6, LAMP_ALL,   1'b0),
      make_word("oneon",    5, LAMP_ONE,   1'b1),
      make_word("oneoff",   6, LAMP_ONE,   1'b0),
      make_word("twoon",    5, LAMP_TWO,   1'b1),
      make_word("twooff",   6, LAMP_TWO,   1'b0),
      make_word("threeon",  7, LAMP_THREE, 1'b1),
      make_word("threeoff", 8, LAMP_THREE, 1'b0)
   };

endpackage

[hw/rtl/serial_text_command_led_control_core.sv]
// Top level: line buffer, command match and lamp state for serial text commands.
`timescale 1ns / 1ps
//
//  channel | dir | tdata fields (low bit first)
//  --------+-----+-----------------------------------------------------------
//  req_    | in  | rx_byte[7:0]
//  rsp_    | out | lamp_one, lamp_two, lamp_three, recognized, 4'b0 pad
//
//  The result of a byte is loaded into the output register at the edge that accepts the
//  byte; a new byte can be taken every cycle unless a result waits on rsp_tready.
//  The single output register holds that result; req_tready drops only while a
//  result waits and rsp_tready is low.
//  Reset clears the fill position, the lamps and the output valid; no clearing pass.
//  Only the first eight line positions are kept, as no word is longer.

module serial_text_command_led_control_core #(
   parameter int LINE_DEPTH = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] lamp_one [1] lamp_two [2] lamp_three
                                   // [3] recognized [7:4] zero
);
   import stcl_pkg::*;

   localparam int POS_W = $clog2(LINE_DEPTH);

   logic [POS_W-1:0]  fill_ff, fill_in;
   logic [LAMP_W-1:0] lamp_ff, lamp_in;
   line_chars_type    line_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              req_fire;
   logic              is_cr;
   match_type         match;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_cr      = (req_tdata == CR_CODE);

   stcl_match #(.POS_W(POS_W)) u_match (
      .line_chars(line_ff),
      .fill_pos  (fill_ff),
      .match     (match)
   );

   always_comb begin
      fill_in      = fill_ff;
      lamp_in      = lamp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         if (is_cr) begin
            fill_in = '0;
            if (match.hit) begin
               lamp_in = match.turn_on ? (lamp_ff | match.mask) : (lamp_ff & ~match.mask);
            end
         end else if (fill_ff == POS_W'(LINE_DEPTH - 1)) begin
            fill_in = '0;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000, is_cr && match.hit, lamp_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         lamp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         lamp_ff      <= lamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < WORD_MAX_LEN; i++) begin
         if (req_fire && !is_cr && (fill_ff == POS_W'(i))) begin
            line_ff[i] <= req_tdata;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_recog_only_on_cr: assert property (@(posedge clock) disable iff (reset)
      req_fire && !is_cr |=> !rsp_data_ff[3])
      else $error("recognized set for a byte that was not carriage return");

   a_cr_rewinds: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_cr |=> fill_ff == '0)
      else $error("fill position not cleared after carriage return");

   a_lamps_need_hit: assert property (@(posedge clock) disable iff (reset)
      lamp_ff != $past(lamp_ff) |-> rsp_data_ff[3])
      else $error("lamps changed without a recognized command");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      req_fire && !is_cr |=> (fill_ff == '0) || (fill_ff == $past(fill_ff) + 1'b1))
      else $error("fill position advanced incorrectly");

endmodule

[hw/rtl/stcl_match.sv]
// Parallel compare of the stored line against the eight command words.
`timescale 1ns / 1ps

module stcl_match #(
   parameter int POS_W = 4
) (
   input  stcl_pkg::line_chars_type line_chars,
   input  logic [POS_W-1:0]         fill_pos,
   output stcl_pkg::match_type      match
);
   import stcl_pkg::*;

   always_comb begin
      logic eq;
      match = '0;
      // walk backwards so the first word in the list wins
      for (int k = WORD_COUNT - 1; k >= 0; k--) begin
         eq = (fill_pos == POS_W'(WORDS[k].len));
         for (int i = 0; i < WORD_MAX_LEN; i++) begin
            if ((i < int'(WORDS[k].len)) && (line_chars[i] != WORDS[k].chars[i])) begin
               eq = 1'b0;
            end
         end
         if (eq) begin
            match.hit     = 1'b1;
            match.mask    = WORDS[k].mask;
            match.turn_on = WORDS[k].turn_on;
         end
      end
   end

endmodule
